FILE: src/euler_totient_trial_division_defines.svh
// Assertion macros for the totient block.
// Depends on nothing; the asserting file provides clk and rst_n.
`ifndef EULER_TOTIENT_TRIAL_DIVISION_DEFINES_SVH
`define EULER_TOTIENT_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define ETT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define ETT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ett_pkg.sv
// Shared types for the totient block: controller states, divider operand
// select, and the command/status structs between controller and datapath.
package ett_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOP_DIV,
    ST_LOOP_WAIT,
    ST_ANS_DIV,
    ST_ANS_WAIT,
    ST_STRIP_DIV,
    ST_STRIP_WAIT,
    ST_FINAL_DIV,
    ST_FINAL_WAIT,
    ST_FINISH
  } ett_state_t;

  // Which operands go to the shared divider
  typedef enum logic [1:0] {
    SEL_REM_BY_D,
    SEL_ANS_BY_D,
    SEL_ANS_BY_REM
  } ett_sel_t;

  typedef struct packed {
    logic     load;      // capture new value, reset d to 2
    logic     start;     // launch a division
    ett_sel_t sel;       // divider operands
    logic     take_rem;  // rem <= quotient
    logic     take_ans;  // ans <= ans - quotient - remainder
    logic     inc_d;     // next candidate divisor
    logic     out_load;  // move answer to output register
  } ett_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic div_zero;   // remainder of last division is zero
    logic div_cont;   // d <= quotient: keep trying candidates
    logic rem_gt1;    // leftover remainder is a prime factor
    logic out_full;   // output register cannot take a new answer
  } ett_sts_t;

endpackage

FILE: src/ett_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by ett_dp.
module ett_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fit;

  // One restoring step
  always_comb begin
    shifted = {acc_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dsr_r};
    fit     = ~diff[W];
  end

  // Next-state of the iteration
  always_comb begin
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = fit ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = acc_r;

endmodule

FILE: src/ett_dp.sv
// Datapath: remainder, running answer, candidate divisor, output register,
// and the shared divider. Depends on ett_pkg and ett_div.
module ett_dp #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [W-1:0]     in_value,
  input  ett_pkg::ett_cmd_t cmd,
  output ett_pkg::ett_sts_t sts,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [W-1:0]     out_totient
);

  import ett_pkg::*;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] ans_r, ans_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W-1:0] tot_r, tot_nxt;
  logic         oval_r, oval_nxt;
  logic [W-1:0] div_a, div_b, quo, rmd;
  logic         div_busy, div_done;

  // Divider operand select
  always_comb begin
    unique case (cmd.sel)
      SEL_REM_BY_D:   begin div_a = rem_r; div_b = d_r;   end
      SEL_ANS_BY_D:   begin div_a = ans_r; div_b = d_r;   end
      SEL_ANS_BY_REM: begin div_a = ans_r; div_b = rem_r; end
      default:        begin div_a = rem_r; div_b = d_r;   end
    endcase
  end

  ett_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rmd)
  );

  // Register updates; ans/p*(p-1) = ans - q - r with ans = q*p + r
  always_comb begin
    rem_nxt  = rem_r;
    ans_nxt  = ans_r;
    d_nxt    = d_r;
    tot_nxt  = tot_r;
    oval_nxt = oval_r;
    if (out_ready) oval_nxt = 1'b0;
    if (cmd.load) begin
      rem_nxt = in_value;
      ans_nxt = in_value;
      d_nxt   = W'(2);
    end
    if (cmd.take_rem) rem_nxt = quo;
    if (cmd.take_ans) ans_nxt = ans_r - quo - rmd;
    if (cmd.inc_d)    d_nxt   = d_r + 1'b1;
    if (cmd.out_load) begin
      tot_nxt  = ans_r;
      oval_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    ans_r <= ans_nxt;
    d_r   <= d_nxt;
    tot_r <= tot_nxt;
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.div_zero = (rmd == '0);
    sts.div_cont = (d_r <= quo);
    sts.rem_gt1  = (rem_r > W'(1));
    sts.out_full = oval_r & ~out_ready;
  end

  assign out_valid   = oval_r;
  assign out_totient = tot_r;

endmodule

FILE: src/ett_ctrl.sv
// Controller state machine sequencing trial divisions on the datapath.
// Depends on ett_pkg.
module ett_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ett_pkg::ett_sts_t sts,
  output ett_pkg::ett_cmd_t cmd
);

  import ett_pkg::*;

  ett_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_REM_BY_D;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOP_DIV;
        end
      end
      // rem / d gives both the loop bound test and divisibility
      ST_LOOP_DIV: begin
        cmd.start = 1'b1;
        cmd.sel   = SEL_REM_BY_D;
        state_nxt = ST_LOOP_WAIT;
      end
      ST_LOOP_WAIT: begin
        if (sts.div_done) begin
          if (!sts.div_cont) begin
            state_nxt = ST_FINAL_DIV;
          end else if (sts.div_zero) begin
            cmd.take_rem = 1'b1;
            state_nxt    = ST_ANS_DIV;
          end else begin
            cmd.inc_d = 1'b1;
            state_nxt = ST_LOOP_DIV;
          end
        end
      end
      ST_ANS_DIV: begin
        cmd.start = 1'b1;
        cmd.sel   = SEL_ANS_BY_D;
        state_nxt = ST_ANS_WAIT;
      end
      ST_ANS_WAIT: begin
        cmd.sel = SEL_ANS_BY_D;
        if (sts.div_done) begin
          cmd.take_ans = 1'b1;
          state_nxt    = ST_STRIP_DIV;
        end
      end
      // Divide the factor out completely
      ST_STRIP_DIV: begin
        cmd.start = 1'b1;
        cmd.sel   = SEL_REM_BY_D;
        state_nxt = ST_STRIP_WAIT;
      end
      ST_STRIP_WAIT: begin
        if (sts.div_done) begin
          if (sts.div_zero) begin
            cmd.take_rem = 1'b1;
            state_nxt    = ST_STRIP_DIV;
          end else begin
            cmd.inc_d = 1'b1;
            state_nxt = ST_LOOP_DIV;
          end
        end
      end
      // Leftover prime factor
      ST_FINAL_DIV: begin
        if (sts.rem_gt1) begin
          cmd.start = 1'b1;
          cmd.sel   = SEL_ANS_BY_REM;
          state_nxt = ST_FINAL_WAIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINAL_WAIT: begin
        cmd.sel = SEL_ANS_BY_REM;
        if (sts.div_done) begin
          cmd.take_ans = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/euler_totient_trial_division.sv
// Euler totient by trial division, one transaction at a time.
// Each trial divisor is tried on the shared bit-serial divider; up to about
// 2^(VALUE_WIDTH/2) divisors are tried. A waiting result sits in the
// output register while the next transaction is accepted.
// Synchronous active-low reset returns the controller to idle, no output.
`include "euler_totient_trial_division_defines.svh"

module euler_totient_trial_division #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_totient
);

  import ett_pkg::*;

  ett_cmd_t cmd;
  ett_sts_t sts;

  ett_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ett_dp #(.W(VALUE_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_totient (out_totient)
  );

  // Checks on controller/datapath cooperation
  `ETT_ASSERT_NOW(a_no_restart, cmd.start, !sts.div_busy, "divider restarted while busy")
  `ETT_ASSERT_NOW(a_load_idle, cmd.load, !sts.div_busy, "new value loaded during a division")
  `ETT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken")

endmodule
